### rtl/dpa_pkg.sv
// Shared types and constants for the disk page allocator.
package dpa_pkg;

	localparam int NumFiles     = 4;
	localparam int PagesPerFile = 1024;
	localparam int PageW        = 10;
	localparam int FileW        = 2;
	localparam int AddrW        = FileW + PageW;
	localparam int CountW       = 11;
	localparam int TotalW       = 13;
	localparam int CfgW         = 11;
	localparam int CfgIdxW      = 3;

	localparam logic [1:0] PS_ALLOCATED = 2'd0;
	localparam logic [1:0] PS_FREE      = 2'd2;
	localparam logic [1:0] PS_UNKNOWN   = 2'd3;

	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_FREE    = 3'd1;
	localparam logic [2:0] MODE_DECLARE = 3'd2;
	localparam logic [2:0] MODE_RESOLVE = 3'd3;
	localparam logic [2:0] MODE_FORMAT  = 3'd4;
	localparam logic [2:0] MODE_UNKNOWN = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NO_SPARE = 2'd2;
	localparam logic [1:0] STAT_WAS_FREE = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_FILE_COUNT = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SINGLE,
		ST_SWEEP,
		ST_DONE
	} dpa_state_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic [1:0]       wr_data;
	} dpa_mem_req_t;

endpackage

### rtl/dpa_page_ram.sv
// Page status store: one write port, one registered read port.
module dpa_page_ram (
	input  logic                 clk,
	input  dpa_pkg::dpa_mem_req_t req,
	output logic [1:0]           rd_data
);
	import dpa_pkg::*;

	logic [1:0] mem_q [NumFiles*PagesPerFile];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

### rtl/disk_page_allocator.sv
// Disk page allocator top level: sequencer, counters and page status store.
//
// Page allocator holding a 2-bit status for 4 x 1024 pages in one synchronous
// RAM. One operation is taken at a time and gives one result. Free and declare
// read the page status and write the new one where needed, skipping a page
// that is out of range. Allocate tries the files in turn and reads the page
// statuses of each file it tries, starting at the file's cursor, until a free
// page is found or every file has been tried. Resolve, format and all-unknown
// walk every page of the active files once, one page per cycle. Store-full and
// unused modes give their result the cycle after the transfer. Configuration
// writes are taken at any time and must come only while the block is idle.
module disk_page_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dpa_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [dpa_pkg::CfgW-1:0]       cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     mode,
	input  logic [dpa_pkg::FileW-1:0]      file_index,
	input  logic [dpa_pkg::PageW-1:0]      page_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [dpa_pkg::FileW-1:0]      alloc_file,
	output logic [dpa_pkg::PageW-1:0]      alloc_page,
	output logic [dpa_pkg::TotalW-1:0]     free_total
);
	import dpa_pkg::*;

	logic [2:0]        file_count_q;
	logic [CfgW-1:0]   pages_q [NumFiles];
	logic [PageW-1:0]  cursor_q [NumFiles];
	logic [CountW-1:0] ffree_q [NumFiles];
	logic [FileW-1:0]  turn_q;
	logic [TotalW-1:0] total_q;

	dpa_state_t        state_q, state_d;
	logic [2:0]        mode_q;
	logic [FileW-1:0]  fi_q, f_q;
	logic [PageW-1:0]  pi_q, c_q;
	logic [CountW-1:0] j_q;          // pages visited in this file
	logic [FileW+1:0]  k_q;          // files tried
	logic              rd_pend_q;    // rd_data holds a status to be checked
	logic [AddrW-1:0]  rd_addr_q;
	logic [1:0]        rd_data;
	dpa_mem_req_t      req;

	logic [2:0]        nf;
	logic [CountW-1:0] np [NumFiles];
	logic [TotalW-1:0] sum_np;

	always_comb begin
		nf = file_count_q;
		if (nf == 3'd0) nf = 3'd1;
		if (nf > 3'(NumFiles)) nf = 3'(NumFiles);
		sum_np = '0;
		for (int i = 0; i < NumFiles; i++) begin
			if (3'(i) >= nf) np[i] = '0;
			else if (pages_q[i] > CountW'(PagesPerFile)) np[i] = CountW'(PagesPerFile);
			else np[i] = pages_q[i];
			sum_np = sum_np + TotalW'(np[i]);
		end
	end

	dpa_page_ram u_ram (
		.clk    (clk),
		.req    (req),
		.rd_data(rd_data)
	);

	logic [CountW-1:0] np_f;
	logic [PageW-1:0]  c_nxt;
	logic [FileW-1:0]  turn_nxt;
	logic              file_ok;
	logic              sweep_issue;
	assign np_f        = np[f_q];
	assign c_nxt       = (CountW'(c_q) + 1'b1 == np_f) ? '0 : c_q + 1'b1;
	assign turn_nxt    = (3'(f_q) + 1'b1 >= nf) ? '0 : f_q + 1'b1;
	assign file_ok     = (ffree_q[f_q] > CountW'(1)) && (np_f != '0);
	assign sweep_issue = (j_q < np_f);

	logic accept;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_ALLOC) begin
						state_d = (total_q == '0) ? ST_DONE : ST_SCAN;
					end else if (mode == MODE_FREE || mode == MODE_DECLARE) begin
						state_d = ST_SINGLE;
					end else if (mode inside {MODE_RESOLVE, MODE_FORMAT, MODE_UNKNOWN}) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (!rd_pend_q) begin
					if (3'(k_q) >= nf) state_d = ST_DONE;
				end else if (rd_data == PS_FREE) begin
					state_d = ST_DONE;
				end
			end
			ST_SINGLE: begin
				if (CountW'(pi_q) >= np[fi_q] || rd_pend_q) state_d = ST_DONE;
			end
			ST_SWEEP: begin
				if (!sweep_issue && 3'(f_q) + 1'b1 >= nf) state_d = ST_DONE;
			end
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the FSM
	assign out_valid = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_count_q <= 3'd1;
			for (int i = 0; i < NumFiles; i++) begin
				pages_q[i]  <= CfgW'(PagesPerFile);
				cursor_q[i] <= '0;
				ffree_q[i]  <= '0;
			end
			turn_q     <= '0;
			total_q    <= '0;
			state_q    <= ST_IDLE;
			rd_pend_q  <= 1'b0;
			status     <= STAT_OK;
			alloc_file <= '0;
			alloc_page <= '0;
			free_total <= '0;
			mode_q     <= '0;
			fi_q       <= '0;
			pi_q       <= '0;
			f_q        <= '0;
			c_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			rd_addr_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FILE_COUNT) file_count_q <= cfg_data[2:0];
				else if (cfg_index <= CfgIdxW'(NumFiles))
					pages_q[FileW'(cfg_index - 1'b1)] <= cfg_data;
			end
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q     <= mode;
						fi_q       <= file_index;
						pi_q       <= page_index;
						rd_pend_q  <= 1'b0;
						status     <= (mode == MODE_ALLOC && total_q == '0) ? STAT_FULL : STAT_OK;
						alloc_file <= '0;
						alloc_page <= '0;
						j_q        <= '0;
						k_q        <= '0;
						c_q        <= '0;
						if (mode == MODE_ALLOC) begin
							f_q <= (3'(turn_q) >= nf) ? '0 : turn_q;
							if (3'(turn_q) >= nf) turn_q <= '0;
						end else begin
							f_q <= '0;
						end
						if (mode == MODE_FORMAT || mode == MODE_UNKNOWN) begin
							for (int i = 0; i < NumFiles; i++) begin
								cursor_q[i] <= '0;
								ffree_q[i]  <= (mode == MODE_FORMAT) ? np[i] : '0;
							end
							turn_q  <= '0;
							total_q <= (mode == MODE_FORMAT) ?
								((sum_np > TotalW'(8191)) ? TotalW'(8191) : sum_np) : '0;
							free_total <= (mode == MODE_FORMAT) ?
								((sum_np > TotalW'(8191)) ? TotalW'(8191) : sum_np) : '0;
						end else begin
							free_total <= total_q;
						end
					end
				end
				ST_SCAN: begin
					if (!rd_pend_q) begin
						// start a file: give up once every file is tried, skip it, or issue first read
						if (3'(k_q) >= nf) begin
							status <= STAT_NO_SPARE;
						end else if (!file_ok) begin
							k_q    <= k_q + 1'b1;
							f_q    <= turn_nxt;
							turn_q <= turn_nxt;
						end else begin
							c_q       <= (CountW'(cursor_q[f_q]) >= np_f) ? '0 : cursor_q[f_q];
							j_q       <= '0;
							rd_pend_q <= 1'b1;
						end
					end else if (rd_data == PS_FREE) begin
						rd_pend_q      <= 1'b0;
						ffree_q[f_q]   <= ffree_q[f_q] - 1'b1;
						total_q        <= total_q - 1'b1;
						free_total     <= total_q - 1'b1;
						alloc_file     <= f_q;
						alloc_page     <= c_q;
						turn_q         <= turn_nxt;
						cursor_q[f_q]  <= c_nxt;
					end else if (j_q + 1'b1 == np_f) begin
						// whole file seen: cursor ends where it began
						rd_pend_q     <= 1'b0;
						cursor_q[f_q] <= c_nxt;
						k_q           <= k_q + 1'b1;
						f_q           <= turn_nxt;
						turn_q        <= turn_nxt;
					end else begin
						c_q <= c_nxt;
						j_q <= j_q + 1'b1;
					end
				end
				ST_SINGLE: begin
					if (CountW'(pi_q) >= np[fi_q]) begin
						rd_pend_q <= 1'b0;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (mode_q == MODE_FREE) begin
							if (rd_data != PS_FREE) begin
								if (ffree_q[fi_q] != '1) ffree_q[fi_q] <= ffree_q[fi_q] + 1'b1;
								if (total_q != '1) begin
									total_q    <= total_q + 1'b1;
									free_total <= total_q + 1'b1;
								end
							end
						end else if (rd_data == PS_FREE) begin
							status <= STAT_WAS_FREE;
						end
					end
				end
				ST_SWEEP: begin
					// check the status read last cycle while the walk issues the next page
					if (rd_pend_q && mode_q == MODE_RESOLVE && rd_data == PS_UNKNOWN) begin
						if (ffree_q[rd_addr_q[AddrW-1:PageW]] != '1)
							ffree_q[rd_addr_q[AddrW-1:PageW]] <=
								ffree_q[rd_addr_q[AddrW-1:PageW]] + 1'b1;
						if (total_q != '1) begin
							total_q    <= total_q + 1'b1;
							free_total <= total_q + 1'b1;
						end
					end
					if (sweep_issue) begin
						rd_pend_q <= (mode_q == MODE_RESOLVE);
						rd_addr_q <= {f_q, j_q[PageW-1:0]};
						j_q       <= j_q + 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						j_q       <= '0;
						if (3'(f_q) + 1'b1 < nf) f_q <= f_q + 1'b1;
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	// memory port requests
	always_comb begin
		req.rd_en   = 1'b0;
		req.rd_addr = '0;
		req.wr_en   = 1'b0;
		req.wr_addr = '0;
		req.wr_data = PS_ALLOCATED;
		case (state_q)
			ST_SCAN: begin
				if (!rd_pend_q) begin
					req.rd_en   = 1'b1;
					req.rd_addr = {f_q, (CountW'(cursor_q[f_q]) >= np_f) ? '0 : cursor_q[f_q]};
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = {f_q, c_nxt};
					if (rd_data == PS_FREE) begin
						req.wr_en   = 1'b1;
						req.wr_addr = {f_q, c_q};
						req.wr_data = PS_ALLOCATED;
					end
				end
			end
			ST_SINGLE: begin
				req.rd_en   = 1'b1;
				req.rd_addr = {fi_q, pi_q};
				if (rd_pend_q && CountW'(pi_q) < np[fi_q]) begin
					if (mode_q == MODE_FREE && rd_data != PS_FREE) begin
						req.wr_en   = 1'b1;
						req.wr_addr = {fi_q, pi_q};
						req.wr_data = PS_FREE;
					end else if (mode_q == MODE_DECLARE && rd_data != PS_FREE) begin
						req.wr_en   = 1'b1;
						req.wr_addr = {fi_q, pi_q};
						req.wr_data = PS_ALLOCATED;
					end
				end
			end
			ST_SWEEP: begin
				if (sweep_issue) begin
					req.rd_en   = 1'b1;
					req.rd_addr = {f_q, j_q[PageW-1:0]};
					if (mode_q != MODE_RESOLVE) begin
						req.wr_en   = 1'b1;
						req.wr_addr = {f_q, j_q[PageW-1:0]};
						req.wr_data = (mode_q == MODE_FORMAT) ? PS_FREE : PS_UNKNOWN;
					end
				end
				if (rd_pend_q && mode_q == MODE_RESOLVE && rd_data == PS_UNKNOWN) begin
					req.wr_en   = 1'b1;
					req.wr_addr = rd_addr_q;
					req.wr_data = PS_FREE;
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/disk_page_allocator_checker.sv
// Checker for the disk page allocator: predicts every transfer and compares the results.
module disk_page_allocator_checker
	import dpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgW-1:0]      cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [2:0]           mode,
	input  logic [FileW-1:0]     file_index,
	input  logic [PageW-1:0]     page_index,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [1:0]           status,
	input  logic [FileW-1:0]     alloc_file,
	input  logic [PageW-1:0]     alloc_page,
	input  logic [TotalW-1:0]    free_total,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]        status;
		logic [FileW-1:0]  file;
		logic [PageW-1:0]  page;
		logic [TotalW-1:0] total;
	} alloc_result_t;

	alloc_result_t expected_q[$];

	// Shadow copy of configuration and allocator state
	int         file_count_r;
	int         pages_r[4];
	logic [1:0] page_map[NumFiles*PagesPerFile];
	int         cursor[NumFiles];
	int         turn;
	int         free_cnt[NumFiles];
	int         total_cnt;

	function automatic int active_files();
		int n;
		n = file_count_r;
		if (n < 1) n = 1;
		if (n > 4) n = 4;
		return n;
	endfunction

	function automatic int file_pages(int f);
		int v;
		if (f >= active_files()) return 0;
		v = pages_r[f];
		if (v > PagesPerFile) v = PagesPerFile;
		return v;
	endfunction

	function automatic void count_free(int f);
		if (free_cnt[f] < 2047) free_cnt[f]++;
		if (total_cnt < 8191) total_cnt++;
	endfunction

	function automatic alloc_result_t predict_alloc(logic [2:0] m, int fi, int pi);
		alloc_result_t r;
		int nf, f, np, c, sum;
		bit found;
		r.status = STAT_OK;
		r.file = '0;
		r.page = '0;
		nf = active_files();
		c = 0;
		found = 0;
		case (m)
			MODE_ALLOC: begin
				if (total_cnt == 0) begin
					r.status = STAT_FULL;
				end else begin
					if (turn >= nf) turn = 0;
					for (int k = 0; k < nf && !found; k++) begin
						f = turn;
						np = file_pages(f);
						if (free_cnt[f] > 1 && np > 0) begin
							c = cursor[f];
							if (c >= np) c = 0;
							for (int j = 0; j < np; j++) begin
								if (page_map[f*PagesPerFile + c] == PS_FREE) begin
									found = 1;
									break;
								end
								c = (c + 1 == np) ? 0 : c + 1;
							end
							cursor[f] = c;
						end
						if (!found) turn = (turn + 1) % nf;
					end
					if (found) begin
						f = turn;
						np = file_pages(f);
						page_map[f*PagesPerFile + c] = PS_ALLOCATED;
						free_cnt[f]--;
						total_cnt--;
						r.file = FileW'(f);
						r.page = PageW'(c);
						turn = (f + 1) % nf;
						cursor[f] = (c + 1 == np) ? 0 : c + 1;
					end else begin
						r.status = STAT_NO_SPARE;
					end
				end
			end
			MODE_FREE, MODE_DECLARE: begin
				if (pi < file_pages(fi)) begin
					if (m == MODE_FREE) begin
						if (page_map[fi*PagesPerFile + pi] != PS_FREE) begin
							page_map[fi*PagesPerFile + pi] = PS_FREE;
							count_free(fi);
						end
					end else if (page_map[fi*PagesPerFile + pi] == PS_FREE) begin
						r.status = STAT_WAS_FREE;
					end else begin
						page_map[fi*PagesPerFile + pi] = PS_ALLOCATED;
					end
				end
			end
			MODE_RESOLVE: begin
				for (f = 0; f < NumFiles; f++)
					for (int p = 0; p < file_pages(f); p++)
						if (page_map[f*PagesPerFile + p] == PS_UNKNOWN) begin
							page_map[f*PagesPerFile + p] = PS_FREE;
							count_free(f);
						end
			end
			MODE_FORMAT, MODE_UNKNOWN: begin
				sum = 0;
				for (f = 0; f < NumFiles; f++) begin
					np = file_pages(f);
					for (int p = 0; p < np; p++)
						page_map[f*PagesPerFile + p] = (m == MODE_FORMAT) ? PS_FREE : PS_UNKNOWN;
					cursor[f] = 0;
					free_cnt[f] = (m == MODE_FORMAT) ? np : 0;
					if (m == MODE_FORMAT) sum += np;
				end
				total_cnt = (sum > 8191) ? 8191 : sum;
				turn = 0;
			end
			default: ;
		endcase
		r.total = TotalW'(total_cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			file_count_r = 1;
			for (int i = 0; i < 4; i++) pages_r[i] = 1024;
			for (int i = 0; i < NumFiles*PagesPerFile; i++) page_map[i] = PS_ALLOCATED;
			for (int i = 0; i < NumFiles; i++) begin
				cursor[i] = 0;
				free_cnt[i] = 0;
			end
			turn = 0;
			total_cnt = 0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FILE_COUNT) file_count_r = cfg_data & 7;
				else if (cfg_index <= REG_FILE_COUNT + 4)
					pages_r[cfg_index - REG_FILE_COUNT - 1] = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						errors++;
					end
					if (alloc_file !== e.file) begin
						$error("alloc_file: expected %0d, got %0d", e.file, alloc_file);
						errors++;
					end
					if (alloc_page !== e.page) begin
						$error("alloc_page: expected %0d, got %0d", e.page, alloc_page);
						errors++;
					end
					if (free_total !== e.total) begin
						$error("free_total: expected %0d, got %0d", e.total, free_total);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_alloc(mode, file_index, page_index));
		end
		pending = expected_q.size();
	end

endmodule

### tb/disk_page_allocator_test.sv
// Testbench top for the disk page allocator: stimulus, flow control and verdict.
module disk_page_allocator_test;
	import dpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         mode = MODE_FORMAT;
	logic [FileW-1:0]   file_index = '0;
	logic [PageW-1:0]   page_index = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [FileW-1:0]   alloc_file;
	logic [PageW-1:0]   alloc_page;
	logic [TotalW-1:0]  free_total;
	int                 errors;
	int                 pending;

	bit hold_req = 0;
	bit calm = 0;
	int burst_left = 0;
	int sent = 0;
	int phases_run = 0;
	int page_cfg[4];

	always #10 clk = ~clk;

	disk_page_allocator i_dut (.*);

	disk_page_allocator_checker i_checker (.*);

	// Receiver: random stall pattern, plus one long hold-off when asked
	initial begin
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	task automatic offer(logic [2:0] m, int f, int p);
		if (!calm && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		file_index <= FileW'(f);
		page_index <= PageW'(p);
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(int cnt, int p0, int p1, int p2, int p3);
		page_cfg = '{p0, p1, p2, p3};
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FILE_COUNT;
		cfg_data <= CfgW'(cnt);
		for (int f = 0; f < 4; f++) begin
			@(posedge clk);
			cfg_index <= CfgIdxW'(REG_FILE_COUNT + 1 + f);
			cfg_data <= CfgW'(page_cfg[f]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	// Mostly allocate and free within range, with bulk modes and noise now and then
	task automatic random_items(int n);
		int r, f, lim;
		logic [2:0] m;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			f = $urandom_range(0, 3);
			lim = (page_cfg[f] > 1024) ? 1024 : page_cfg[f];
			if (r < 42) m = MODE_ALLOC;
			else if (r < 70) m = MODE_FREE;
			else if (r < 86) m = MODE_DECLARE;
			else if (r < 90) m = MODE_RESOLVE;
			else if (r < 93) m = MODE_FORMAT;
			else if (r < 95) m = MODE_UNKNOWN;
			else m = (r < 97) ? MODE_SPARE_A : MODE_SPARE_B;
			if (lim > 0 && $urandom_range(0, 9) != 0)
				offer(m, f, $urandom_range(0, lim - 1));
			else
				offer(m, f, $urandom_range(0, 1023));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bulk modes, field extremes, declare and free corners
		configure(1, 16, 16, 16, 16);
		calm = 1;
		offer(MODE_UNKNOWN, 0, 0);
		offer(MODE_ALLOC, 0, 0);
		offer(MODE_RESOLVE, 0, 0);
		offer(MODE_ALLOC, 3, 1023);
		offer(MODE_FORMAT, 0, 0);
		offer(MODE_DECLARE, 0, 15);
		offer(MODE_DECLARE, 0, 0);
		offer(MODE_ALLOC, 0, 0);
		offer(MODE_ALLOC, 0, 0);
		offer(MODE_FREE, 0, 1);
		offer(MODE_FREE, 0, 1);
		offer(MODE_FREE, 0, 16);
		offer(MODE_FREE, 3, 1023);
		offer(MODE_DECLARE, 3, 2);
		offer(MODE_SPARE_A, 2, 5);
		offer(MODE_SPARE_B, 1, 682);
		offer(MODE_DECLARE, 0, 1);
		offer(MODE_ALLOC, 0, 0);
		calm = 0;
		random_items(100);
		drain();

		configure(4, 8, 5, 3, 2);
		offer(MODE_FORMAT, 0, 0);
		hold_req = 1;
		random_items(120);
		drain();

		configure(2, 32, 0, 7, 9);
		offer(MODE_UNKNOWN, 0, 0);
		random_items(120);
		drain();

		configure(0, 20, 12, 12, 12);
		offer(MODE_FORMAT, 0, 0);
		calm = 1;
		random_items(60);
		calm = 0;
		random_items(60);
		drain();

		configure(7, 2047, 6, 1, 4);
		offer(MODE_FORMAT, 0, 0);
		random_items(40);
		drain();

		configure(4, 1024, 1024, 1024, 1024);
		offer(MODE_FORMAT, 0, 0);
		random_items(30);
		drain();

		configure(3, 1, 2, 1, 64);
		offer(MODE_FORMAT, 0, 0);
		random_items(100);
		drain();

		configure(4, 64, 48, 33, 17);
		offer(MODE_UNKNOWN, 0, 0);
		random_items(130);
		drain();

		$display("Ran %0d operations over %0d file layouts, from single-page files", sent,
			phases_run);
		$display("to four full files, with random stalls and one long result hold-off.");
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

### filelist.f
rtl/dpa_pkg.sv
rtl/dpa_page_ram.sv
rtl/disk_page_allocator.sv
tb/disk_page_allocator_checker.sv
tb/disk_page_allocator_test.sv
